[rtl/spi_pkg.sv]
`timescale 1ns / 1ps
package spi_pkg;

	localparam int COORD_WIDTH_DEF = 10;
	localparam int CANVAS_W        = 11;
	localparam int MAXSTEP_W       = 6;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 11;

	localparam logic [CANVAS_W-1:0]  CANVAS_RST    = 11'd512;
	localparam logic [MAXSTEP_W-1:0] MAXSTEP_RST   = 6'd30;
	localparam logic [MAXSTEP_W-1:0] MAXSTEP_LIMIT = 6'd32;
	localparam logic [MAXSTEP_W-1:0] MAXSTEP_MIN   = 6'd1;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXSTEP = 1'b1;

	localparam logic OP_PRESS = 1'b0;
	localparam logic OP_DRAG  = 1'b1;

	typedef struct packed {
		logic init;
		logic advance;
	} axis_ctrl_t;

endpackage

[rtl/spi_step_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module spi_step_div #(
	parameter int DW = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [DW-1:0]                  dividend,
	input  logic [spi_pkg::MAXSTEP_W-1:0]  divisor,
	output logic                           done,
	output logic [DW-1:0]                  quotient
);

	localparam int VW   = spi_pkg::MAXSTEP_W;
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [VW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [VW:0] trial;
	logic        ge;
	logic [VW:0] trial_sub;

	assign trial     = {rem_q, dvd_q[DW-1]};
	assign ge        = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in behind the dividend
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/spi_axis.sv]
`timescale 1ns / 1ps
// one axis of the walk: keeps floor(i*mag/span) as quotient and remainder
module spi_axis #(
	parameter int CW = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  spi_pkg::axis_ctrl_t ctrl,
	input  logic [CW-1:0]       pos,
	input  logic [CW-1:0]       last,
	input  logic [CW-1:0]       span,
	output logic [CW-1:0]       mag,
	output logic [CW-1:0]       point
);

	logic [CW-1:0] q_q;
	logic [CW-1:0] r_q;

	logic [CW:0]   diff;
	logic [CW:0]   diff_abs;
	logic          neg;
	logic [CW:0]   rsum;
	logic          over;
	logic [CW:0]   rnext;
	logic [CW-1:0] offset;

	assign diff     = {1'b0, pos} - {1'b0, last};
	assign neg      = diff[CW];
	assign diff_abs = neg ? (~diff + 1'b1) : diff;
	assign mag      = diff_abs[CW-1:0];

	assign rsum  = {1'b0, r_q} + {1'b0, mag};
	assign over  = rsum >= {1'b0, span};
	assign rnext = over ? (rsum - {1'b0, span}) : rsum;

	// negative direction: floor of a negative ratio is -(q + (r != 0))
	assign offset = neg ? (~q_q + CW'(r_q == '0)) : q_q;
	assign point  = last + offset;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			q_q <= '0;
			r_q <= '0;
		end else if (ctrl.advance) begin
			q_q <= over ? (q_q + 1'b1) : q_q;
			r_q <= rnext[CW-1:0];
		end
	end

endmodule

[rtl/stroke_point_interpolator.sv]
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    operation, pos_x, pos_y
// out      output     out_valid / out_ready  stamp_x, stamp_y, last_of_run
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// Press: accept, then stamp. Drag: accept and setup, then the divider when the span exceeds
// the step threshold, then the walk through the indices up to the last stamped one; a
// zero-length drag ends after setup.
// A new request is taken only between events; the output register holds one stamp.
// The walk and the press stamp pause while the output register is full and not taken.
// Reset clears control, the last position and restores register defaults.
module stroke_point_interpolator #(
	parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [COORD_WIDTH-1:0]              pos_x,
	input  logic [COORD_WIDTH-1:0]              pos_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_WIDTH-1:0]              stamp_x,
	output logic signed [COORD_WIDTH+1:0]       stamp_y,
	output logic                                last_of_run,
	input  logic                                cfg_we,
	input  logic [spi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW = COORD_WIDTH;
	localparam int YW = CW + 2;
	localparam int SW = (YW > spi_pkg::CANVAS_W) ? YW : spi_pkg::CANVAS_W;
	localparam int MW = spi_pkg::MAXSTEP_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PRESS = 5'b00010,
		ST_SETUP = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_WALK  = 5'b10000
	} state_t;

	state_t state_q;

	logic [spi_pkg::CANVAS_W-1:0] canvas_q;
	logic [MW-1:0]                maxstep_q;

	logic [CW-1:0] pos_x_q;
	logic [CW-1:0] pos_y_q;
	logic [CW-1:0] last_x_q;
	logic [CW-1:0] last_y_q;
	logic [CW-1:0] span_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;

	logic          out_valid_q;
	logic [CW-1:0] stamp_x_q;
	logic [YW-1:0] stamp_y_q;
	logic          last_q;

	spi_pkg::axis_ctrl_t axis_ctrl;
	logic [CW-1:0] mag_x;
	logic [CW-1:0] mag_y;
	logic [CW-1:0] pt_x;
	logic [CW-1:0] pt_y;
	logic [CW-1:0] span_c;
	logic [MW-1:0] msteps;

	logic          div_start;
	logic          div_done;
	logic [CW-1:0] div_quot;

	logic          out_free;
	logic          emit;
	logic          run_end;
	logic          walk_adv;
	logic          out_load;
	logic [CW:0]   idx_next_sum;
	logic [CW-1:0] src_x;
	logic [CW-1:0] src_y;
	logic [SW-1:0] ydiff;

	always_comb begin
		if (maxstep_q == '0)
			msteps = spi_pkg::MAXSTEP_MIN;
		else if (maxstep_q > spi_pkg::MAXSTEP_LIMIT)
			msteps = spi_pkg::MAXSTEP_LIMIT;
		else
			msteps = maxstep_q;
	end

	assign span_c = (mag_x > mag_y) ? mag_x : mag_y;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || out_ready;
	assign emit         = (cnt_q == '0);
	assign idx_next_sum = {1'b0, idx_q} + {1'b0, step_q};
	assign run_end      = emit && (idx_next_sum >= {1'b0, span_q});
	assign walk_adv     = (state_q == ST_WALK) && (!emit || out_free);

	assign axis_ctrl.init    = (state_q == ST_SETUP);
	assign axis_ctrl.advance = walk_adv;

	assign div_start = (state_q == ST_SETUP) && (span_c != '0)
		&& ({{(CW > MW ? CW - MW : 0){1'b0}}, msteps} < span_c);

	assign out_load = ((state_q == ST_PRESS) && out_free)
		|| ((state_q == ST_WALK) && emit && out_free);

	assign src_x = (state_q == ST_PRESS) ? pos_x_q : pt_x;
	assign src_y = (state_q == ST_PRESS) ? pos_y_q : pt_y;
	assign ydiff = SW'(canvas_q) - SW'(src_y);

	spi_axis #(.CW(CW)) u_axis_x (
		.clk   (clk),
		.ctrl  (axis_ctrl),
		.pos   (pos_x_q),
		.last  (last_x_q),
		.span  (span_q),
		.mag   (mag_x),
		.point (pt_x)
	);

	spi_axis #(.CW(CW)) u_axis_y (
		.clk   (clk),
		.ctrl  (axis_ctrl),
		.pos   (pos_y_q),
		.last  (last_y_q),
		.span  (span_q),
		.mag   (mag_y),
		.point (pt_y)
	);

	spi_step_div #(.DW(CW)) u_step_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span_c),
		.divisor  (msteps),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_q  <= spi_pkg::CANVAS_RST;
			maxstep_q <= spi_pkg::MAXSTEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spi_pkg::REG_CANVAS:  canvas_q  <= cfg_data;
				spi_pkg::REG_MAXSTEP: maxstep_q <= cfg_data[MW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= (operation == spi_pkg::OP_PRESS) ? ST_PRESS : ST_SETUP;
				end
				ST_PRESS: begin
					if (out_free) begin
						last_x_q <= pos_x_q;
						last_y_q <= pos_y_q;
						state_q  <= ST_IDLE;
					end
				end
				ST_SETUP: begin
					if (span_c == '0) begin
						last_x_q <= pos_x_q;
						last_y_q <= pos_y_q;
						state_q  <= ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_adv && run_end) begin
						last_x_q <= pos_x_q;
						last_y_q <= pos_y_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
		end
		if (state_q == ST_SETUP) begin
			span_q <= span_c;
			step_q <= CW'(1);
			cnt_q  <= '0;
			idx_q  <= '0;
		end
		if ((state_q == ST_DIV) && div_done)
			step_q <= div_quot;
		if (walk_adv) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= emit ? (step_q - 1'b1) : (cnt_q - 1'b1);
		end
		if (out_load) begin
			stamp_x_q <= src_x;
			stamp_y_q <= ydiff[YW-1:0];
			last_q    <= (state_q == ST_PRESS) || run_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign stamp_x     = stamp_x_q;
	assign stamp_y     = stamp_y_q;
	assign last_of_run = last_q;

endmodule

[test/stroke_point_interpolator_tb.sv]
`timescale 1ns / 1ps
module stroke_point_interpolator_tb;

	localparam int CW          = spi_pkg::COORD_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic          op;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		bit            hold;
	} pointer_req_t;

	typedef struct {
		logic [CW-1:0]        x;
		logic signed [CW+1:0] y;
		logic                 last;
	} stamp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = spi_pkg::OP_PRESS;
	logic [CW-1:0] pos_x = '0;
	logic [CW-1:0] pos_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CW-1:0] stamp_x;
	logic signed [CW+1:0] stamp_y;
	logic last_of_run;
	logic cfg_we = 1'b0;
	logic [spi_pkg::CFG_IDX_W-1:0] cfg_index = spi_pkg::REG_CANVAS;
	logic [spi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	pointer_req_t stroke_requests[$];
	stamp_t due_stamps[$];
	pointer_req_t next_req;
	stamp_t got_stamp;

	// predictor copy of registers and last position
	logic [spi_pkg::CANVAS_W-1:0] canvas_setting = spi_pkg::CANVAS_RST;
	logic [spi_pkg::MAXSTEP_W-1:0] step_cap = spi_pkg::MAXSTEP_RST;
	logic [CW-1:0] trail_x = '0;
	logic [CW-1:0] trail_y = '0;

	// generator's view of the last position
	int gen_x = 0;
	int gen_y = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;
	bit accepted;

	stroke_point_interpolator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stamp_x     (stamp_x),
		.stamp_y     (stamp_y),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int floor_div(input int num, input int den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	task automatic add_stamp(input int sx, input int sy, input bit last);
		stamp_t s;
		int flipped;
		flipped = int'(canvas_setting) - sy;
		s.x = sx[CW-1:0];
		s.y = flipped[CW+1:0];
		s.last = last;
		due_stamps.push_back(s);
	endtask

	task automatic trace_segment(input logic op, input logic [CW-1:0] x,
			input logic [CW-1:0] y);
		int dx, dy, ax, ay, span, cap, stride, i;
		if (op == spi_pkg::OP_PRESS) begin
			add_stamp(int'(x), int'(y), 1'b1);
		end else begin
			dx = int'(x) - int'(trail_x);
			dy = int'(y) - int'(trail_y);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			span = ax > ay ? ax : ay;
			cap = int'(step_cap);
			if (cap < int'(spi_pkg::MAXSTEP_MIN))
				cap = int'(spi_pkg::MAXSTEP_MIN);
			if (cap > int'(spi_pkg::MAXSTEP_LIMIT))
				cap = int'(spi_pkg::MAXSTEP_LIMIT);
			stride = span > cap ? span / cap : 1;
			for (i = 0; i < span; i += stride)
				add_stamp(int'(trail_x) + floor_div(i * dx, span),
					int'(trail_y) + floor_div(i * dy, span), (i + stride) >= span);
		end
		trail_x = x;
		trail_y = y;
	endtask

	// driver: predict on acceptance, then present the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= spi_pkg::OP_PRESS;
			pos_x <= '0;
			pos_y <= '0;
			trail_x = '0;
			trail_y = '0;
		end else begin
			accepted = in_valid && in_ready;
			if (accepted)
				trace_segment(operation, pos_x, pos_y);
			if (!in_valid || accepted) begin
				if (stroke_requests.size() > 0 &&
						!(stroke_requests[0].hold && due_stamps.size() > 0) &&
						$urandom_range(99) >= send_idle_pct) begin
					next_req = stroke_requests.pop_front();
					in_valid <= 1'b1;
					operation <= next_req.op;
					pos_x <= next_req.x;
					pos_y <= next_req.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_stamps.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected stamp x=%0d y=%0d last=%b", $time,
							stamp_x, stamp_y, last_of_run);
					mismatches++;
				end else begin
					got_stamp = due_stamps.pop_front();
					if (stamp_x !== got_stamp.x || stamp_y !== got_stamp.y ||
							last_of_run !== got_stamp.last) begin
						if (mismatches < 10)
							$display("%0t: stamp mismatch exp x=%0d y=%0d last=%b got x=%0d y=%0d last=%b",
								$time, got_stamp.x, got_stamp.y, got_stamp.last,
								stamp_x, stamp_y, last_of_run);
						mismatches++;
					end
				end
			end
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL stroke_point_interpolator");
			$finish;
		end
	end

	task automatic write_reg(input logic [spi_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[spi_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == spi_pkg::REG_CANVAS)
			canvas_setting = value[spi_pkg::CANVAS_W-1:0];
		else
			step_cap = value[spi_pkg::MAXSTEP_W-1:0];
	endtask

	task automatic add_request(input logic op, input int x, input int y, input bit hold);
		pointer_req_t r;
		r.op = op;
		r.x = x[CW-1:0];
		r.y = y[CW-1:0];
		r.hold = hold;
		stroke_requests.push_back(r);
		gen_x = x;
		gen_y = y;
	endtask

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > (1 << CW) - 1)
			return (1 << CW) - 1;
		return v;
	endfunction

	// mostly short drags near the last point, some presses, zero and long drags
	task automatic add_random_requests(input int n);
		int k, r;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 25)
				add_request(spi_pkg::OP_PRESS, $urandom_range((1 << CW) - 1),
					$urandom_range((1 << CW) - 1), k == n / 2);
			else if (r < 33)
				add_request(spi_pkg::OP_DRAG, gen_x, gen_y, k == n / 2);
			else if (r < 43)
				add_request(spi_pkg::OP_DRAG, $urandom_range((1 << CW) - 1),
					$urandom_range((1 << CW) - 1), k == n / 2);
			else
				add_request(spi_pkg::OP_DRAG, clamp_coord(gen_x + $urandom_range(80) - 40),
					clamp_coord(gen_y + $urandom_range(80) - 40), k == n / 2);
		end
	endtask

	// all requests taken, all stamps seen, then let a trailing zero drag finish
	task automatic drain;
		while (stroke_requests.size() > 0 || in_valid)
			@(posedge clk);
		while (due_stamps.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		add_random_requests(n);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: canvas 512, max steps 30
		add_request(spi_pkg::OP_PRESS, 0, 0, 1'b0);
		add_request(spi_pkg::OP_PRESS, 1023, 1023, 1'b0);
		add_request(spi_pkg::OP_DRAG, 1023, 1023, 1'b0);
		add_request(spi_pkg::OP_DRAG, 0, 0, 1'b0);
		add_request(spi_pkg::OP_DRAG, 30, 0, 1'b0);
		add_request(spi_pkg::OP_DRAG, 0, 31, 1'b0);
		add_request(spi_pkg::OP_DRAG, 61, 0, 1'b0);
		add_request(spi_pkg::OP_DRAG, 61, 0, 1'b0);
		add_request(spi_pkg::OP_PRESS, 512, 100, 1'b0);
		add_request(spi_pkg::OP_DRAG, 500, 700, 1'b1);
		add_request(spi_pkg::OP_DRAG, 1023, 0, 1'b0);
		add_request(spi_pkg::OP_PRESS, 5, 1023, 1'b0);
		add_request(spi_pkg::OP_DRAG, 0, 1023, 1'b0);
		add_request(spi_pkg::OP_DRAG, 1, 1022, 1'b0);
		add_request(spi_pkg::OP_DRAG, 0, 1023, 1'b0);
		add_request(spi_pkg::OP_DRAG, 682, 341, 1'b0);
		run_phase(0, 0, 30);

		write_reg(spi_pkg::REG_CANVAS, 1024);
		write_reg(spi_pkg::REG_MAXSTEP, 32);
		run_phase(58, 0, 32);

		write_reg(spi_pkg::REG_CANVAS, 1);
		write_reg(spi_pkg::REG_MAXSTEP, 1);
		run_phase(0, 58, 32);

		// zero max steps acts as one; canvas at field top
		write_reg(spi_pkg::REG_CANVAS, 2047);
		write_reg(spi_pkg::REG_MAXSTEP, 0);
		run_phase(6, 6, 32);

		// max steps above the cap saturates
		write_reg(spi_pkg::REG_CANVAS, 0);
		write_reg(spi_pkg::REG_MAXSTEP, 63);
		run_phase(0, 0, 32);

		write_reg(spi_pkg::REG_CANVAS, $urandom_range(1024, 1));
		write_reg(spi_pkg::REG_MAXSTEP, $urandom_range(31, 2));
		run_phase(6, 6, 32);

		if (mismatches == 0 && due_stamps.size() == 0)
			$display("PASS stroke_point_interpolator");
		else
			$display("FAIL stroke_point_interpolator");
		$finish;
	end

endmodule

[sim.f]
rtl/spi_pkg.sv
rtl/spi_step_div.sv
rtl/spi_axis.sv
rtl/stroke_point_interpolator.sv
test/stroke_point_interpolator_tb.sv
